/* sv/days_between_dates_top_defines.svh */
// Assertion macros for the checks inside the days between dates block.
// Every assertion is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef DAYS_BETWEEN_DATES_TOP_DEFINES_SVH
`define DAYS_BETWEEN_DATES_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dbd_pkg.sv */
`default_nettype none

package dbd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int DOY_W   = 9;
	localparam int Q100_W  = 8;
	localparam int DN_W    = 23;
	localparam int COUNT_W = 22;

	localparam logic [YEAR_W-1:0] SWITCH_YEAR_RESET = YEAR_W'(1583);

	// floor(x / 100) is (x * DIV100_MUL) >> DIV100_SHIFT for every 14-bit x.
	localparam int DIV100_MUL   = 20972;
	localparam int DIV100_SHIFT = 21;
	localparam int PROD_W       = 29;

	// Century correction of the reset switch year: ceil(y/100) - ceil(y/400).
	localparam logic [Q100_W-1:0] G_SW_RESET =
		Q100_W'((1583 + 99) / 100 - (1583 + 399) / 400);

	localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [YEAR_W-1:0]  year_t;
	typedef logic [MONTH_W-1:0] month_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [DOY_W-1:0]   doy_t;
	typedef logic [Q100_W-1:0]  q100_t;
	typedef logic [DN_W-1:0]    day_num_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		year_t  year;
		month_t month;
		day_t   day;
	} date_t;

	// Days in months before month m of a common year; months 13 to 15 run on
	// as 31-day months and month 0 counts like January.
	function automatic doy_t month_start(input month_t m);
		doy_t r;
		case (m)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			4'd13:   r = 9'd365;
			4'd14:   r = 9'd396;
			default: r = 9'd427;
		endcase
		return r;
	endfunction

	function automatic q100_t div100(input year_t y);
		logic [PROD_W-1:0] p;
		p = PROD_W'(y) * PROD_W'(DIV100_MUL);
		return p[PROD_W-1:DIV100_SHIFT];
	endfunction

	// Century correction ceil(y/100) - ceil(y/400), taken apart from floor(y/100).
	function automatic q100_t century_corr(input q100_t f100, input logic exact100);
		q100_t c100;
		q100_t c400;
		c100 = f100 + q100_t'(!exact100);
		c400 = (f100 >> 2) + q100_t'((f100[1:0] != 2'd0) || !exact100);
		return c100 - c400;
	endfunction

endpackage

`default_nettype wire

/* sv/dbd_date_pipe.sv */
`default_nettype none

module dbd_date_pipe (
	input  wire                clk,
	input  wire                en,
	input  dbd_pkg::date_t     date,
	input  dbd_pkg::year_t     switch_year,
	input  dbd_pkg::q100_t     g_sw,
	output dbd_pkg::day_num_t  day_num
);
	import dbd_pkg::*;

	// Stage 1: month offset, era select and the year divided by 100.
	year_t    year_s1;
	logic     julian_s1;
	doy_t     doy_s1;
	logic     late_s1;
	q100_t    f100_s1;

	// Stage 2: Julian base days and century test.
	logic     julian_s2;
	doy_t     doy_s2;
	logic     late_s2;
	q100_t    f100_s2;
	logic     exact100_s2;
	logic     div4_s2;
	day_num_t jbase_s2;

	// Stage 3: leap day applied, Gregorian correction formed.
	day_num_t part_s3;
	q100_t    corr_s3;

	// Stage 4: finished day number.
	day_num_t dn_s4;

	logic [YEAR_W:0] year_p3;
	logic            leap;
	q100_t           corr;

	assign year_p3 = {1'b0, year_s1} + (YEAR_W+1)'(3);
	assign leap    = julian_s2 ? div4_s2 : (exact100_s2 ? (f100_s2[1:0] == 2'd0) : div4_s2);
	assign corr    = julian_s2 ? '0 : century_corr(f100_s2, exact100_s2) - g_sw;

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1   <= date.year;
			julian_s1 <= date.year < switch_year;
			doy_s1    <= month_start(date.month) + DOY_W'(date.day);
			late_s1   <= date.month >= 4'd3;
			f100_s1   <= div100(date.year);

			julian_s2   <= julian_s1;
			doy_s2      <= doy_s1;
			late_s2     <= late_s1;
			f100_s2     <= f100_s1;
			exact100_s2 <= (15'(f100_s1) * 15'd100) == 15'(year_s1);
			div4_s2     <= year_s1[1:0] == 2'd0;
			jbase_s2    <= DN_W'(year_s1) * DN_W'(365) + DN_W'(year_p3 >> 2);

			part_s3 <= jbase_s2 + DN_W'(doy_s2) + DN_W'(leap && late_s2);
			corr_s3 <= corr;

			dn_s4 <= part_s3 - DN_W'(corr_s3);
		end
	end

	assign day_num = dn_s4;

endmodule

`default_nettype wire

/* sv/dbd_diff.sv */
`default_nettype none

module dbd_diff (
	input  wire                clk,
	input  wire                en,
	input  dbd_pkg::day_num_t  dn_first,
	input  dbd_pkg::day_num_t  dn_second,
	output dbd_pkg::count_t    day_count,
	output logic               order_error
);
	import dbd_pkg::*;

	count_t   count_s5;
	logic     err_s5;
	day_num_t diff;

	assign diff = dn_second - dn_first;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dn_second < dn_first) begin
				count_s5 <= '0;
				err_s5   <= 1'b1;
			end else begin
				// Differences past the field range clamp to full scale.
				count_s5 <= diff[DN_W-1] ? DAY_COUNT_MAX : diff[COUNT_W-1:0];
				err_s5   <= 1'b0;
			end
		end
	end

	assign day_count   = count_s5;
	assign order_error = err_s5;

endmodule

`default_nettype wire

/* sv/days_between_dates_top.sv */
// Days between two dates, Julian years before a programmable switch year and
// Gregorian years from it on.
// Input channel s_*: one beat carries both dates; s_tdata from bit 0 up holds
// first_year[13:0], first_month[17:14], first_day[22:18], second_year[36:23],
// second_month[40:37], second_day[45:41], and bits 47:46 are zero.
// Output channel m_*: m_tdata[21:0] is day_count, m_tuser[0] is order_error.
// When the second date precedes the first, order_error is 1 and day_count is 0;
// counts beyond 22 bits clamp to full scale.
// cfg_we/cfg_wdata load switch_year (reset 1583) and must be used only while no
// beat is in flight; the century correction is registered from the stored switch_year.
// Throughput is one beat per cycle while the output is not stalled. A beat passes
// five register stages: the four date stages, then the output register.
// All stages advance together; when the receiver holds m_tready low with a result
// waiting, s_tready falls and every stage holds, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and restores switch_year.
`default_nettype none

`include "days_between_dates_top_defines.svh"

module days_between_dates_top (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration write: switch_year.
	input  wire         cfg_we,
	input  wire  [13:0] cfg_wdata,
	// Input beats.
	input  wire         s_tvalid,
	output logic        s_tready,
	// first_year, first_month, first_day, second_year, second_month, second_day, pad
	input  wire  [47:0] s_tdata,
	// Output beats.
	output logic        m_tvalid,
	input  wire         m_tready,
	// day_count, pad
	output logic [23:0] m_tdata,
	// order_error
	output logic [0:0]  m_tuser
);
	import dbd_pkg::*;

	year_t    switch_year_q;
	q100_t    g_sw_q;
	logic     v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic     adv;
	date_t    date_a, date_b;
	day_num_t dn_a, dn_b;
	count_t   day_count;
	logic     order_error;

	// The whole pipeline moves whenever the output register is free or being drained.
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, day_count};
	assign m_tuser  = order_error;

	assign date_a = '{year: s_tdata[13:0], month: s_tdata[17:14], day: s_tdata[22:18]};
	assign date_b = '{year: s_tdata[36:23], month: s_tdata[40:37], day: s_tdata[45:41]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_year_q <= SWITCH_YEAR_RESET;
			g_sw_q        <= G_SW_RESET;
		end else begin
			if (cfg_we) begin
				switch_year_q <= cfg_wdata;
			end
			// Century correction of the switch year, used from stage 2 on.
			g_sw_q <= century_corr(div100(switch_year_q),
				(15'(div100(switch_year_q)) * 15'd100) == 15'(switch_year_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	dbd_date_pipe u_first (
		.clk         (clk),
		.en          (adv),
		.date        (date_a),
		.switch_year (switch_year_q),
		.g_sw        (g_sw_q),
		.day_num     (dn_a)
	);

	dbd_date_pipe u_second (
		.clk         (clk),
		.en          (adv),
		.date        (date_b),
		.switch_year (switch_year_q),
		.g_sw        (g_sw_q),
		.day_num     (dn_b)
	);

	dbd_diff u_diff (
		.clk         (clk),
		.en          (adv),
		.dn_first    (dn_a),
		.dn_second   (dn_b),
		.day_count   (day_count),
		.order_error (order_error)
	);

	// Input is refused only while a finished result waits at the output.
	`DBD_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid, "input stalled with output empty")

	// A valid stage-4 item reaches the output register when the pipeline moves.
	`DBD_ASSERT_NEXT(a_s4_to_out, v_s4 && s_tready, m_tvalid, "stage 4 item lost")

	// An order error always carries a zero count.
	`DBD_ASSERT_NOW(a_error_zero, m_tvalid && m_tuser[0], m_tdata[21:0] == 22'd0, "error with count")

endmodule

`default_nettype wire

/* verif/days_between_dates_top_tb.sv */
`default_nettype none

// Keeps the expected day counts in arrival order and checks each output beat.
class days_between_predictor;
	typedef struct {
		dbd_pkg::count_t days;
		logic            reversed;
	} count_expect_t;

	dbd_pkg::year_t gregorian_from = dbd_pkg::SWITCH_YEAR_RESET;
	count_expect_t  expected_counts[$];
	int             failures = 0;
	int             checked = 0;
	int             reversed_seen = 0;
	int             clamped_seen = 0;

	// Cumulative days before each month of a common year, months 0 to 15.
	int unsigned days_before_month[16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
		273, 304, 334, 365, 396, 427};

	function void set_gregorian_from(dbd_pkg::year_t y);
		gregorian_from = y;
	endfunction

	function int pending();
		return expected_counts.size();
	endfunction

	function longint julian_days(longint y);
		return 365 * y + (y + 3) / 4;
	endfunction

	function longint gregorian_days(longint y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Absolute day number of a date; year zero is the origin.
	function longint day_index(dbd_pkg::date_t dt);
		longint y;
		longint sw;
		longint base;
		longint doy;
		bit     leap;
		y = longint'(dt.year);
		sw = longint'(gregorian_from);
		if (y < sw) begin
			base = julian_days(y);
			leap = (y % 4) == 0;
		end else begin
			base = julian_days(sw) + gregorian_days(y) - gregorian_days(sw);
			leap = ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
		end
		doy = longint'(days_before_month[dt.month]) + longint'(dt.day);
		if (leap && dt.month >= 4'd3)
			doy = doy + 1;
		return base + doy;
	endfunction

	function void note_dates(dbd_pkg::date_t first, dbd_pkg::date_t second);
		count_expect_t e;
		longint        a;
		longint        b;
		longint        diff;
		a = day_index(first);
		b = day_index(second);
		if (b < a) begin
			e.days = '0;
			e.reversed = 1'b1;
			reversed_seen++;
		end else begin
			diff = b - a;
			if (diff > longint'(dbd_pkg::DAY_COUNT_MAX)) begin
				diff = longint'(dbd_pkg::DAY_COUNT_MAX);
				clamped_seen++;
			end
			e.days = dbd_pkg::count_t'(diff);
			e.reversed = 1'b0;
		end
		expected_counts.push_back(e);
	endfunction

	function void check_count(dbd_pkg::count_t got_days, logic got_reversed);
		count_expect_t e;
		if (expected_counts.size() == 0) begin
			$display("%0t: unexpected result day_count=%0d order_error=%0b", $time,
				got_days, got_reversed);
			failures++;
			return;
		end
		e = expected_counts.pop_front();
		checked++;
		if (got_days !== e.days) begin
			$display("%0t: day_count mismatch, expected %0d, actual %0d", $time,
				e.days, got_days);
			failures++;
		end
		if (got_reversed !== e.reversed) begin
			$display("%0t: order_error mismatch, expected %0b, actual %0b", $time,
				e.reversed, got_reversed);
			failures++;
		end
	endfunction
endclass

module days_between_dates_top_tb;
	import dbd_pkg::*;

	// This many idle cycles are enough for anything still in flight to come out
	// before a register write or the end.
	localparam int SETTLE_CYCLES = 10;
	// Run limit in time units, far beyond the slowest correct run.
	localparam int RUN_LIMIT = 400000;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 130;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [13:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int     idle_pct = 0;
	int     stall_pct = 0;
	year_t  switch_setting = SWITCH_YEAR_RESET;
	int     settings_used = 1;

	days_between_predictor board = new();

	days_between_dates_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #1 clk = ~clk;

	// The receiver decides at each falling edge whether it takes a beat at the
	// next rising edge. Its value is held until the following falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Output beats are sampled at the rising edge; the testbench changes every value
	// that it drives only at a falling edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_count(m_tdata[21:0], m_tuser[0]);
	end

	function automatic date_t make_date(int y, int m, int d);
		date_t dt;
		dt.year = year_t'(y);
		dt.month = month_t'(m);
		dt.day = day_t'(d);
		return dt;
	endfunction

	function automatic int clamp_year(int y);
		if (y < 0)
			return 0;
		if (y > 16383)
			return 16383;
		return y;
	endfunction

	// Years are mostly in the documented range, often close to the switch year
	// and sometimes anywhere the 14-bit field reaches. Months and days are usually
	// valid but now and then take any value the field holds, zero included.
	function automatic date_t random_date();
		int y;
		int m;
		int d;
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			y = $urandom_range(9999, 1);
		else if (pick < 75)
			y = clamp_year(int'(switch_setting) + int'($urandom_range(6)) - 3);
		else
			y = $urandom_range(16383);
		if ($urandom_range(99) < 85)
			m = $urandom_range(12, 1);
		else
			m = $urandom_range(15);
		if ($urandom_range(99) < 85)
			d = $urandom_range(31, 1);
		else
			d = $urandom_range(31);
		return make_date(y, m, d);
	endfunction

	// One input beat: optional idle cycles, then tvalid held until the block
	// takes the beat. The prediction is made only once the beat is accepted.
	task automatic send_date_pair(input date_t first, input date_t second);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, second.day, second.month, second.year,
			first.day, first.month, first.year};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_dates(first, second);
	endtask

	// The sender stops and waits for every predicted result to come out, then
	// lets the pipeline settle.
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The switch year may only change with the pipeline empty. The block registers
	// its century correction from the new value, so a short pause follows.
	task automatic write_switch_year(input year_t value);
		wait_results_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_gregorian_from(value);
		switch_setting = value;
		settings_used++;
		repeat (2) @(negedge clk);
	endtask

	// Most pairs are ordered so that the second date follows the first, either
	// close by or anywhere later. The rest are reversed pairs, identical dates or
	// a second date one day number lower, and unordered noise.
	task automatic send_random_pairs(input int count);
		date_t a;
		date_t b;
		date_t t;
		int    pick;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_results_drained();
			a = random_date();
			b = random_date();
			pick = $urandom_range(99);
			if (pick < 40) begin
				b.year = year_t'(clamp_year(int'(a.year) + int'($urandom_range(3))));
				if (b < a) begin
					t = a;
					a = b;
					b = t;
				end
			end else if (pick < 70) begin
				if (b < a) begin
					t = a;
					a = b;
					b = t;
				end
			end else if (pick < 80) begin
				if (a < b) begin
					t = a;
					a = b;
					b = t;
				end
			end else if (pick < 88) begin
				b = a;
				if ($urandom_range(1) == 1)
					b.day = a.day - day_t'(1);
			end
			send_date_pair(a, b);
		end
	endtask

	initial begin
		int     idle_modes[4];
		int     stall_modes[4];
		year_t  settings[PHASES];
		idle_modes = '{0, 62, 0, 11};
		stall_modes = '{0, 0, 62, 11};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		settings[0] = year_t'(1752);
		settings[1] = year_t'(0);
		settings[2] = year_t'(16383);
		settings[3] = SWITCH_YEAR_RESET;
		settings[4] = year_t'($urandom_range(9999, 1));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed pairs with the reset switch year of 1583.
		// Identical dates, then the widest span of the documented range.
		send_date_pair(make_date(2000, 1, 1), make_date(2000, 1, 1));
		send_date_pair(make_date(1, 1, 1), make_date(9999, 12, 31));
		// A second date that precedes the first by one day, and by more.
		send_date_pair(make_date(2020, 3, 1), make_date(2020, 2, 29));
		send_date_pair(make_date(9999, 12, 31), make_date(1, 1, 1));
		// Spans that cross into the first Gregorian year.
		send_date_pair(make_date(1582, 10, 4), make_date(1583, 1, 1));
		send_date_pair(make_date(1582, 12, 31), make_date(1583, 1, 1));
		send_date_pair(make_date(1200, 6, 15), make_date(2024, 6, 15));
		// Century years: Julian leap, Gregorian leap and Gregorian common.
		send_date_pair(make_date(1500, 2, 28), make_date(1500, 3, 1));
		send_date_pair(make_date(1600, 2, 28), make_date(1600, 3, 1));
		send_date_pair(make_date(1700, 2, 28), make_date(1700, 3, 1));
		send_date_pair(make_date(1900, 2, 28), make_date(1900, 3, 1));
		send_date_pair(make_date(2000, 2, 28), make_date(2000, 3, 1));
		// Month zero counts like January; months 13 to 15 run on past December.
		send_date_pair(make_date(2001, 0, 5), make_date(2001, 1, 5));
		send_date_pair(make_date(2001, 12, 31), make_date(2001, 15, 31));
		send_date_pair(make_date(2001, 13, 1), make_date(2002, 1, 1));
		// Day zero and days past the end of a month are taken as they stand.
		send_date_pair(make_date(2004, 2, 31), make_date(2004, 3, 0));
		send_date_pair(make_date(2003, 4, 0), make_date(2003, 3, 31));
		// Year zero is a leap year.
		send_date_pair(make_date(0, 1, 1), make_date(0, 3, 1));
		// Years beyond 9999 and a span that clamps to full scale.
		send_date_pair(make_date(9999, 12, 31), make_date(16383, 15, 31));
		send_date_pair(make_date(0, 0, 0), make_date(16383, 15, 31));
		send_date_pair(make_date(16383, 15, 31), make_date(16383, 15, 31));
		send_date_pair(make_date(16383, 15, 31), make_date(0, 0, 0));

		// Random phases, each under its own switch year, with idle and stall patterns taken in turn.
		for (int p = 0; p < PHASES; p++) begin
			write_switch_year(settings[p]);
			idle_pct = idle_modes[p % 4];
			stall_pct = stall_modes[p % 4];
			if (p == 1 || p == 2) begin
				// Year zero and full-scale years next to a switch year of zero or full scale.
				send_date_pair(make_date(0, 2, 29), make_date(1, 1, 1));
				send_date_pair(make_date(16382, 1, 1), make_date(16383, 12, 31));
			end
			send_random_pairs(ITEMS_PER_PHASE);
		end

		idle_pct = 0;
		stall_pct = 0;
		wait_results_drained();

		$display("Run covered %0d date pairs under %0d switch-year settings,",
			board.checked, settings_used);
		$display("0 and 16383 among them; reversed pairs flagged: %0d; clamped counts: %0d.",
			board.reversed_seen, board.clamped_seen);
		if (board.failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#RUN_LIMIT;
		$display("status: fail");
		$finish;
	end
endmodule

`default_nettype wire
